// ----- src/ahdlc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the HDLC framer.
`default_nettype none
package ahdlc_pkg;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  XOR_MASK  = 8'h20;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic        open;
      logic        last;
      logic [7:0]  data;
      logic [15:0] crc;
   } ahdlc_entry_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- src/ahdlc_front.sv -----
// Front end: accepts payload bytes, tracks frame state and runs the CRC.
`default_nettype none
module ahdlc_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [7:0]                 req_tdata,   // [7:0] payload_byte
   input  wire                        req_tlast,   // frame_last
   output logic                       push,
   output ahdlc_pkg::ahdlc_entry_type push_entry,
   input  wire                        queue_full
);
   import ahdlc_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic        inside_ff, inside_in;
   logic [15:0] crc_next;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      crc_next  = crc_byte(inside_ff ? crc_ff : CRC_INIT, req_tdata);
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (push) begin
         crc_in    = req_tlast ? CRC_INIT : crc_next;
         inside_in = !req_tlast;
      end
      push_entry.open = !inside_ff;
      push_entry.last = req_tlast;
      push_entry.data = req_tdata;
      push_entry.crc  = crc_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         inside_ff <= inside_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/ahdlc_queue.sv -----
// Short queue of classified bytes between front and back end.
`default_nettype none
module ahdlc_queue #(
   parameter int QUEUE_DEPTH = ahdlc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  ahdlc_pkg::ahdlc_entry_type push_entry,
   output logic                       full,
   input  wire                        pop,
   output ahdlc_pkg::ahdlc_entry_type pop_entry,
   output logic                       not_empty
);
   import ahdlc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ahdlc_entry_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- src/ahdlc_back.sv -----
// Back end: sequences flags, stuffed data and CRC bytes into the output register.
`default_nettype none
module ahdlc_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        entry_valid,
   input  ahdlc_pkg::ahdlc_entry_type entry,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] line_byte
   output logic                       rsp_tlast    // run_last
);
   import ahdlc_pkg::*;

   typedef enum logic [4:0] {
      PH_HEAD   = 5'b00001,
      PH_DATA   = 5'b00010,
      PH_CRC_HI = 5'b00100,
      PH_CRC_LO = 5'b01000,
      PH_CLOSE  = 5'b10000
   } ahdlc_phase_type;

   ahdlc_phase_type phase_ff, phase_in, phase_eff;
   logic            esc_ff, esc_in;
   logic            valid_ff, valid_in;
   logic [7:0]      data_ff, data_in;
   logic            last_ff, last_in;
   logic            load;
   logic [7:0]      cur;
   logic            special;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign load       = entry_valid && (!valid_ff || rsp_tready);

   always_comb begin
      phase_eff = (phase_ff == PH_HEAD && !entry.open) ? PH_DATA : phase_ff;
      unique case (phase_eff)
         PH_CRC_HI: cur = entry.crc[15:8];
         PH_CRC_LO: cur = entry.crc[7:0];
         default:   cur = entry.data;
      endcase
      special  = (cur == FLAG_BYTE) || (cur == ESC_BYTE);
      phase_in = phase_ff;
      esc_in   = esc_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_tready;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         unique case (phase_eff)
            PH_HEAD: begin
               data_in  = FLAG_BYTE;
               phase_in = PH_DATA;
            end
            PH_CLOSE: begin
               data_in  = FLAG_BYTE;
               last_in  = 1'b1;
               pop      = 1'b1;
               phase_in = PH_HEAD;
            end
            default: begin
               if (special && !esc_ff) begin
                  data_in = ESC_BYTE;
                  esc_in  = 1'b1;
               end else begin
                  data_in = esc_ff ? (cur ^ XOR_MASK) : cur;
                  esc_in  = 1'b0;
                  if (phase_eff == PH_DATA) begin
                     if (entry.last) begin
                        phase_in = PH_CRC_HI;
                     end else begin
                        last_in  = 1'b1;
                        pop      = 1'b1;
                        phase_in = PH_HEAD;
                     end
                  end else if (phase_eff == PH_CRC_HI) begin
                     phase_in = PH_CRC_LO;
                  end else begin
                     phase_in = PH_CLOSE;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEAD;
         esc_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

// ----- src/async_hdlc_framer_crc16_unit.sv -----
// Top level: HDLC framer with byte stuffing and CRC-16 trailer.
// An item's first line byte goes through the queue, then the output register.
// Throughput: one line byte per cycle from the output register unless stalled;
// an item yields 1 to 8 bytes (opening flag, escapes, CRC bytes, closing flag).
// Input is taken every cycle while the byte queue between the ends has room.
// Synchronous reset clears frame state, CRC to 0xFFFF, queue and output valid.
`default_nettype none
module async_hdlc_framer_crc16_unit #(
   parameter int QUEUE_DEPTH = ahdlc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] payload_byte
   input  wire        req_tlast,   // frame_last
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tlast    // run_last
);
   import ahdlc_pkg::*;

   logic            push, pop, queue_full, queue_valid;
   ahdlc_entry_type push_entry, pop_entry;

   ahdlc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   ahdlc_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (queue_valid)
   );

   ahdlc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- src/ahdlc_checker.sv -----
// Port-level checker for the HDLC framer, bound to the top level.
`default_nettype none
module ahdlc_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast
);
   import ahdlc_pkg::*;

   logic esc_seen_ff, esc_seen_in;
   logic rsp_xfer;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      esc_seen_in = esc_seen_ff;
      if (rsp_xfer) begin
         esc_seen_in = (rsp_tdata == ESC_BYTE) && !esc_seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_seen_ff <= 1'b0;
      end else begin
         esc_seen_ff <= esc_seen_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output transaction changed");

   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == ESC_BYTE && !esc_seen_ff |-> !rsp_tlast)
      else $error("escape byte closed a run");

   a_esc_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && esc_seen_ff |->
         (rsp_tdata == (FLAG_BYTE ^ XOR_MASK)) || (rsp_tdata == (ESC_BYTE ^ XOR_MASK)))
      else $error("escape not followed by a stuffed flag or escape");

endmodule

bind async_hdlc_framer_crc16_unit ahdlc_checker u_ahdlc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the HDLC framer: predicts stuffed line bytes and CRC trailers.
`timescale 1ns / 1ps
module testbench;
   import ahdlc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PER_PHASE = 60;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
   } line_item_type;

   class framer_scoreboard;
      line_item_type line_bytes_due[$];
      logic [7:0]    burst[$];
      logic [15:0]   crc_acc;
      bit            frame_open;
      int            errors, items, lines, frames, max_burst;

      function new();
         crc_acc = CRC_INIT;
         frame_open = 1'b0;
         errors = 0;
         items = 0;
         lines = 0;
         frames = 0;
         max_burst = 0;
      endfunction

      // MSB-first CRC-16/CCITT, one input bit per iteration
      static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
         end
         return c;
      endfunction

      function void push_stuffed(logic [7:0] b);
         if (b == FLAG_BYTE || b == ESC_BYTE) begin
            burst.push_back(ESC_BYTE);
            burst.push_back(b ^ XOR_MASK);
         end else begin
            burst.push_back(b);
         end
      endfunction

      function void note_payload(logic [7:0] b, logic l);
         line_item_type li;
         burst.delete();
         items++;
         if (!frame_open) begin
            burst.push_back(FLAG_BYTE);
            crc_acc = CRC_INIT;
            frame_open = 1'b1;
         end
         crc_acc = crc16_step(crc_acc, b);
         push_stuffed(b);
         if (l) begin
            push_stuffed(crc_acc[15:8]);
            push_stuffed(crc_acc[7:0]);
            burst.push_back(FLAG_BYTE);
            crc_acc = CRC_INIT;
            frame_open = 1'b0;
            frames++;
         end
         if (burst.size() > max_burst) max_burst = burst.size();
         for (int i = 0; i < burst.size(); i++) begin
            li.line_byte = burst[i];
            li.run_last = (i == burst.size() - 1);
            line_bytes_due.push_back(li);
         end
      endfunction

      function void check_line(logic [7:0] b, logic l);
         line_item_type due;
         if (line_bytes_due.size() == 0) begin
            errors++;
            $error("unexpected line byte %02h (run_last %0b)", b, l);
            return;
         end
         due = line_bytes_due.pop_front();
         lines++;
         if (b !== due.line_byte) begin
            errors++;
            $error("line_byte: expected %02h, actual %02h", due.line_byte, b);
         end
         if (l !== due.run_last) begin
            errors++;
            $error("run_last: expected %0b, actual %0b", due.run_last, l);
         end
      endfunction

      function int pending();
         return line_bytes_due.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] payload_byte
   logic       req_tlast = 1'b0;    // frame_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] line_byte
   logic       rsp_tlast;           // run_last

   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  cycle_count = 0;

   framer_scoreboard sb = new();

   async_hdlc_framer_crc16_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_line(rsp_tdata, rsp_tlast);
   end

   task automatic send_payload(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_payload(b, l);
   endtask

   task automatic send_random(input int count);
      logic [7:0] b;
      int         pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(9);
         case (pick)
            0: b = FLAG_BYTE;
            1: b = ESC_BYTE;
            default: b = 8'($urandom_range(255));
         endcase
         send_payload(b, $urandom_range(99) < 30);
      end
   endtask

   // two-byte prefix that drives the CRC of {prefix, tail} to the given value
   function automatic logic [15:0] crc_prefix_for(logic [15:0] target, logic [7:0] tail);
      logic [15:0] c;
      for (int v = 0; v < 65536; v++) begin
         c = framer_scoreboard::crc16_step(CRC_INIT, v[15:8]);
         c = framer_scoreboard::crc16_step(c, v[7:0]);
         c = framer_scoreboard::crc16_step(c, tail);
         if (c == target) return v[15:0];
      end
      return 16'h0000;
   endfunction

   task automatic send_crc_stuff_frame(input logic [15:0] target, input logic [7:0] tail);
      logic [15:0] prefix;
      prefix = crc_prefix_for(target, tail);
      send_payload(prefix[15:8], 1'b0);
      send_payload(prefix[7:0], 1'b0);
      send_payload(tail, 1'b1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single-byte frames at the extremes and around the escape codes
      send_payload(8'h00, 1'b1);
      send_payload(8'hFF, 1'b1);
      send_payload(FLAG_BYTE, 1'b1);
      send_payload(ESC_BYTE, 1'b1);
      send_payload(FLAG_BYTE ^ XOR_MASK, 1'b1);
      send_payload(ESC_BYTE ^ XOR_MASK, 1'b1);
      // escapes inside a longer frame
      send_payload(ESC_BYTE, 1'b0);
      send_payload(FLAG_BYTE, 1'b0);
      send_payload(8'hAA, 1'b0);
      send_payload(8'h55, 1'b1);
      send_payload(8'h80, 1'b0);
      send_payload(8'h01, 1'b0);
      send_payload(8'h7F, 1'b1);
      // both CRC bytes need escaping
      send_crc_stuff_frame({FLAG_BYTE, ESC_BYTE}, FLAG_BYTE);
      send_crc_stuff_frame({ESC_BYTE, FLAG_BYTE}, ESC_BYTE);

      send_random(RANDOM_PER_PHASE);
      drain();

      sender_idle_pct = 77;
      send_random(RANDOM_PER_PHASE);
      drain();

      sender_idle_pct = 0;
      receiver_stall_pct = 77;
      send_random(RANDOM_PER_PHASE);
      drain();

      sender_idle_pct = 10;
      receiver_stall_pct = 10;
      send_random(RANDOM_PER_PHASE);
      drain();
      repeat (20) @(posedge clock);

      if (sb.pending() != 0) begin
         sb.errors++;
         $error("%0d line bytes never arrived", sb.pending());
      end
      $display("Sent %0d payload bytes in %0d closed frames; checked %0d line bytes.",
               sb.items, sb.frames, sb.lines);
      $display("Largest burst for one payload byte: %0d line bytes; idle/stall mixes: 4.",
               sb.max_burst);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
src/ahdlc_pkg.sv
src/ahdlc_front.sv
src/ahdlc_queue.sv
src/ahdlc_back.sv
src/async_hdlc_framer_crc16_unit.sv
src/ahdlc_checker.sv
tb/sv/testbench.sv
